### sv/bra_pkg.sv
// Shared types, constants and a helper function of the bitmap range allocator.
// No dependencies; the interfaces, the top module and the bench refer to it by scoped names.
package bra_pkg;

	localparam int WORD_BITS    = 64;
	localparam int MAP_BITS_DEF = 1024;
	localparam int CMD_W        = 3;
	localparam int START_W      = 10;
	localparam int LEN_W        = 11;
	localparam int ALIGN_W      = 10;
	localparam int POS_W        = 12;
	localparam int SIZE_W       = 11;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic [SIZE_W-1:0]  MAP_SIZE_RST = 11'd1024;
	localparam logic [PADDR_W-1:0] REG_MAP_SIZE = 3'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET      = 3'd0,
		CMD_CLR      = 3'd1,
		CMD_TEST     = 3'd2,
		CMD_NEXT_SET = 3'd3,
		CMD_NEXT_CLR = 3'd4,
		CMD_AREA     = 3'd5,
		CMD_CLR_ALL  = 3'd6,
		CMD_NOP      = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ALIGN,
		S_CHECK,
		S_DONE
	} state_t;

	// Index of the lowest set bit; zero for an all-zero word.
	function automatic logic [5:0] lsb_index(input logic [WORD_BITS-1:0] w);
		logic [5:0] n;
		n = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				n = 6'(i);
			end
		end
		return n;
	endfunction

endpackage

### sv/bra_if.sv
// Valid/ready channel interfaces for the command and result words.
// Depends on bra_pkg for the field widths.
interface bra_req_if;
	logic                          valid;
	logic                          ready;
	logic [bra_pkg::CMD_W-1:0]     cmd;
	logic [bra_pkg::START_W-1:0]   start_pos;
	logic [bra_pkg::LEN_W-1:0]     run_length;
	logic [bra_pkg::ALIGN_W-1:0]   area_mask;
	logic [bra_pkg::ALIGN_W-1:0]   area_offset;

	modport source (output valid, cmd, start_pos, run_length, area_mask, area_offset,
		input ready);
	modport sink (input valid, cmd, start_pos, run_length, area_mask, area_offset,
		output ready);
endinterface

interface bra_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [bra_pkg::POS_W-1:0] position;
	logic                      found;
	logic                      bit_value;

	modport source (output valid, position, found, bit_value, input ready);
	modport sink (input valid, position, found, bit_value, output ready);
endinterface

### sv/bitmap_range_allocator_top.sv
// Bitmap range allocator: the map lives in one RAM of 64-bit words, walked one word a cycle.
// An area search costs, per attempt, one find of a clear bit, the align and check states and
// one find of a set bit; clear all writes one map word per cycle. One command is worked at a time.
// After reset a clearing pass writes zero to all ceil(MAP_BITS/64) words before the first
// command is accepted; configuration writes are taken throughout.
module bitmap_range_allocator_top #(
	parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bra_req_if.sink                      req,
	bra_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bra_pkg::PADDR_W-1:0]  paddr,
	input  logic [bra_pkg::PDATA_W-1:0]  pwdata,
	output logic [bra_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int WB        = bra_pkg::WORD_BITS;
	localparam int MAP_WORDS = (MAP_BITS + WB - 1) / WB;
	localparam int ADW       = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int AW        = $clog2(MAP_BITS + 2048) + 1;
	localparam int WCW       = AW - 6;
	localparam int TW        = $clog2(MAP_BITS + 3);
	localparam int TRY_LAST  = MAP_BITS + 1;

	bra_pkg::state_t state_q, state_d;
	bra_pkg::cmd_t   cmd_q, in_cmd;

	logic [bra_pkg::SIZE_W-1:0]  map_size_q;
	logic [bra_pkg::LEN_W-1:0]   len_q;
	logic [bra_pkg::ALIGN_W-1:0] amask_q, aoff_q;

	logic [AW-1:0]  scan_pos_q, scan_pos_d, scan_lim_q, scan_lim_d;
	logic           scan_inv_q, scan_inv_d, scan_mod_q, scan_mod_d, scan_set_q, scan_set_d;
	logic [WCW-1:0] addr_q, addr_d, addr_s1;
	logic           s1_valid_q, issue;
	logic           phase_q, phase_d, from_cmd_q, from_cmd_d, launch;
	logic [TW-1:0]  try_q, try_d;
	logic [ADW-1:0] clr_q, clr_d;
	logic [AW-1:0]  f_q, f_d;
	logic [AW:0]    idx_q, idx_d, end_q, end_d;

	logic [bra_pkg::POS_W-1:0] res_pos_q, res_pos_d;
	logic                      res_found_q, res_found_d, res_bit_q, res_bit_d;
	logic                      out_valid_q, out_load;

	logic [AW-1:0]  sz, in_end, in_start, align_t, align_m, r_pos, hit_pos;
	logic [AW:0]    last_sum, chk_end;
	logic [WB-1:0]  rd_data, lo_m, hi_m, rng_m, hit_v, wr_data;
	logic           empty, hit, last, fin, in_acc, ram_we, chk_fail;
	logic [ADW-1:0] ram_waddr;

	assign pready = 1'b1;
	assign prdata = (paddr == bra_pkg::REG_MAP_SIZE) ?
		bra_pkg::PDATA_W'(map_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_size_q <= bra_pkg::MAP_SIZE_RST;
		end else if (psel && penable && pwrite && paddr == bra_pkg::REG_MAP_SIZE) begin
			map_size_q <= pwdata[bra_pkg::SIZE_W-1:0];
		end
	end

	assign sz = (AW'(map_size_q) > AW'(MAP_BITS)) ? AW'(MAP_BITS) : AW'(map_size_q);

	assign req.ready = (state_q == bra_pkg::S_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign in_cmd    = bra_pkg::cmd_t'(req.cmd);
	assign in_start  = AW'(req.start_pos);
	assign in_end    = in_start + AW'(req.run_length);

	// Word scan: the word at addr_s1 arrives from the RAM while the next one is read.
	assign empty   = scan_pos_q >= scan_lim_q;
	assign lo_m    = (addr_s1 == scan_pos_q[AW-1:6]) ? ({WB{1'b1}} << scan_pos_q[5:0])
		: {WB{1'b1}};
	assign hi_m    = (addr_s1 < scan_lim_q[AW-1:6]) ? {WB{1'b1}}
		: ((WB'(1) << scan_lim_q[5:0]) - WB'(1));
	assign rng_m   = lo_m & hi_m;
	assign hit_v   = (rd_data ^ {WB{scan_inv_q}}) & rng_m;
	assign hit     = s1_valid_q && !scan_mod_q && (|hit_v);
	assign last_sum = {1'b0, addr_s1, 6'b0} + (AW+1)'(WB);
	assign last    = last_sum >= {1'b0, scan_lim_q};
	assign hit_pos = {addr_s1, bra_pkg::lsb_index(hit_v)};
	assign r_pos   = hit ? hit_pos : scan_lim_q;
	assign fin     = (state_q == bra_pkg::S_SCAN) && (empty || (s1_valid_q && (hit || last)));
	assign issue   = (state_q == bra_pkg::S_SCAN) && !empty && !(s1_valid_q && (hit || last))
		&& ({addr_q, 6'b0} < scan_lim_q);
	assign wr_data = scan_set_q ? (rd_data | rng_m) : (rd_data & ~rng_m);

	assign align_t  = f_q + AW'(aoff_q) + AW'(amask_q);
	assign align_m  = align_t & ~AW'(amask_q);
	assign chk_end  = idx_q + (AW+1)'(len_q);
	assign chk_fail = idx_q[AW] || (idx_q > (AW+1)'(sz)) || (chk_end > (AW+1)'(sz));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1[ADW-1:0];
		if (state_q == bra_pkg::S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (state_q == bra_pkg::S_SCAN && s1_valid_q && scan_mod_q) begin
			ram_we = 1'b1;
		end
	end

	bra_ram #(
		.WIDTH(WB),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ((state_q == bra_pkg::S_CLEAR) ? '0 : wr_data),
		.raddr (addr_q[ADW-1:0]),
		.rdata (rd_data)
	);

	always_comb begin
		state_d     = state_q;
		scan_pos_d  = scan_pos_q;
		scan_lim_d  = scan_lim_q;
		scan_inv_d  = scan_inv_q;
		scan_mod_d  = scan_mod_q;
		scan_set_d  = scan_set_q;
		addr_d      = issue ? addr_q + WCW'(1) : addr_q;
		phase_d     = phase_q;
		from_cmd_d  = from_cmd_q;
		try_d       = try_q;
		clr_d       = clr_q;
		f_d         = f_q;
		idx_d       = idx_q;
		end_d       = end_q;
		res_pos_d   = res_pos_q;
		res_found_d = res_found_q;
		res_bit_d   = res_bit_q;
		launch      = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			bra_pkg::S_CLEAR: begin
				if (clr_q == ADW'(MAP_WORDS - 1)) begin
					state_d    = from_cmd_q ? bra_pkg::S_DONE : bra_pkg::S_IDLE;
					from_cmd_d = 1'b0;
				end else begin
					clr_d = clr_q + ADW'(1);
				end
			end
			bra_pkg::S_IDLE: begin
				if (in_acc) begin
					res_pos_d   = '0;
					res_found_d = 1'b0;
					res_bit_d   = 1'b0;
					scan_pos_d  = in_start;
					scan_mod_d  = 1'b0;
					scan_inv_d  = 1'b0;
					unique case (in_cmd)
						bra_pkg::CMD_SET, bra_pkg::CMD_CLR: begin
							scan_lim_d = (in_end > AW'(MAP_BITS)) ? AW'(MAP_BITS) : in_end;
							scan_mod_d = 1'b1;
							scan_set_d = (in_cmd == bra_pkg::CMD_SET);
							launch     = 1'b1;
						end
						bra_pkg::CMD_TEST: begin
							scan_lim_d = (in_start >= AW'(MAP_BITS)) ? AW'(MAP_BITS)
								: in_start + AW'(1);
							launch     = 1'b1;
						end
						bra_pkg::CMD_NEXT_SET, bra_pkg::CMD_NEXT_CLR: begin
							scan_lim_d = sz;
							scan_inv_d = (in_cmd == bra_pkg::CMD_NEXT_CLR);
							launch     = 1'b1;
						end
						bra_pkg::CMD_AREA: begin
							scan_lim_d = sz;
							scan_inv_d = 1'b1;
							phase_d    = 1'b0;
							try_d      = '0;
							launch     = 1'b1;
						end
						bra_pkg::CMD_CLR_ALL: begin
							clr_d      = '0;
							from_cmd_d = 1'b1;
							state_d    = bra_pkg::S_CLEAR;
						end
						bra_pkg::CMD_NOP: begin
							state_d = bra_pkg::S_DONE;
						end
					endcase
				end
			end
			bra_pkg::S_SCAN: begin
				if (fin) begin
					state_d = bra_pkg::S_DONE;
					unique case (cmd_q)
						bra_pkg::CMD_TEST: begin
							res_bit_d = hit;
						end
						bra_pkg::CMD_NEXT_SET, bra_pkg::CMD_NEXT_CLR: begin
							res_pos_d   = r_pos[bra_pkg::POS_W-1:0];
							res_found_d = hit;
						end
						bra_pkg::CMD_AREA: begin
							if (!phase_q) begin
								f_d     = r_pos;
								state_d = bra_pkg::S_ALIGN;
							end else if (!hit) begin
								res_pos_d   = idx_q[bra_pkg::POS_W-1:0];
								res_found_d = 1'b1;
							end else if (try_q == TW'(TRY_LAST)) begin
								// Attempt budget spent: report the last end as a failure.
								res_pos_d = end_q[bra_pkg::POS_W-1:0];
							end else begin
								try_d      = try_q + TW'(1);
								scan_pos_d = r_pos + AW'(1);
								scan_lim_d = sz;
								scan_inv_d = 1'b1;
								phase_d    = 1'b0;
								launch     = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			bra_pkg::S_ALIGN: begin
				idx_d   = {1'b0, align_m} - (AW+1)'(aoff_q);
				state_d = bra_pkg::S_CHECK;
			end
			bra_pkg::S_CHECK: begin
				end_d = chk_end;
				if (chk_fail) begin
					res_pos_d = chk_end[bra_pkg::POS_W-1:0];
					state_d   = bra_pkg::S_DONE;
				end else begin
					// Look for any set bit inside the candidate area.
					scan_pos_d = idx_q[AW-1:0];
					scan_lim_d = chk_end[AW-1:0];
					scan_inv_d = 1'b0;
					phase_d    = 1'b1;
					launch     = 1'b1;
				end
			end
			bra_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = bra_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bra_pkg::S_IDLE;
			end
		endcase
		if (launch) begin
			state_d = bra_pkg::S_SCAN;
			addr_d  = scan_pos_d[AW-1:6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bra_pkg::S_CLEAR;
			clr_q       <= '0;
			from_cmd_q  <= 1'b0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			try_q       <= '0;
			addr_q      <= '0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			from_cmd_q <= from_cmd_d;
			s1_valid_q <= issue;
			phase_q    <= phase_d;
			try_q      <= try_d;
			addr_q     <= addr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= addr_q;
		scan_pos_q <= scan_pos_d;
		scan_lim_q <= scan_lim_d;
		scan_inv_q <= scan_inv_d;
		scan_mod_q <= scan_mod_d;
		scan_set_q <= scan_set_d;
		f_q        <= f_d;
		idx_q      <= idx_d;
		end_q      <= end_d;
		res_pos_q  <= res_pos_d;
		res_found_q <= res_found_d;
		res_bit_q  <= res_bit_d;
		if (in_acc) begin
			cmd_q   <= in_cmd;
			len_q   <= req.run_length;
			amask_q <= req.area_mask;
			aoff_q  <= req.area_offset;
		end
		if (out_load) begin
			rsp.position  <= res_pos_q;
			rsp.found     <= res_found_q;
			rsp.bit_value <= res_bit_q;
		end
	end

	assign rsp.valid = out_valid_q;

`ifndef SYNTH
	// The map is never written while no command is at work.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bra_pkg::S_IDLE |-> !ram_we)
		else $error("map written while idle");

	// Read data is only consumed by an active scan.
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> state_q == bra_pkg::S_SCAN)
		else $error("word returned outside a scan");

	// An accepted command always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != bra_pkg::S_IDLE)
		else $error("command accepted but not started");

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("result overwritten");

	// The retry count stays within its budget.
	a_try_bound: assert property (@(posedge clk) disable iff (!arst_n)
		try_q <= TW'(TRY_LAST))
		else $error("retry count out of range");
`endif

endmodule

### sv/bra_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bra_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sim/testbench.sv
// Self-checking bench for the bitmap range allocator: directed, random and stall tests.
// Depends on bra_pkg, the request/response interfaces and bitmap_range_allocator_top.
module testbench;

	localparam int MAP_N       = 1024;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [bra_pkg::POS_W-1:0] position;
		logic                      found;
		logic                      bit_value;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [bra_pkg::PADDR_W-1:0] paddr = '0;
	logic [bra_pkg::PDATA_W-1:0] pwdata = '0;
	logic [bra_pkg::PDATA_W-1:0] prdata;
	logic pready;

	bra_req_if req ();
	bra_rsp_if rsp ();

	bitmap_range_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the block's state.
	bit [MAP_N-1:0] shadow_map;
	logic [bra_pkg::SIZE_W-1:0] shadow_size;

	answer_t pending_answers[$];
	int mismatches = 0;
	int cycles = 0;
	int rsp_wait = 0;
	int rsp_hold = 0;
	bit quiet = 0;

	initial begin
		req.valid = 1'b0;
		req.cmd = '0;
		req.start_pos = '0;
		req.run_length = '0;
		req.area_mask = '0;
		req.area_offset = '0;
		rsp.ready = 1'b0;
	end

	function automatic longint unsigned scan_for(longint unsigned nbits,
			longint unsigned from, bit want);
		for (longint unsigned p = from; p < nbits; p++) begin
			if (shadow_map[p] == want) begin
				return p;
			end
		end
		return nbits;
	endfunction

	function automatic answer_t predict(bra_pkg::cmd_t c, logic [bra_pkg::START_W-1:0] st,
			logic [bra_pkg::LEN_W-1:0] ln, logic [bra_pkg::ALIGN_W-1:0] am,
			logic [bra_pkg::ALIGN_W-1:0] ao);
		answer_t a;
		longint unsigned sz, len, msk, off, s, idx, e, hit, pos;
		a = '0;
		pos = 0;
		len = ln;
		msk = am;
		off = ao;
		sz = (shadow_size < MAP_N) ? shadow_size : MAP_N;
		case (c)
			bra_pkg::CMD_SET, bra_pkg::CMD_CLR: begin
				for (longint unsigned i = 0; i < len; i++) begin
					if (st + i < MAP_N) begin
						shadow_map[st + i] = (c == bra_pkg::CMD_SET);
					end
				end
			end
			bra_pkg::CMD_TEST: a.bit_value = shadow_map[st];
			bra_pkg::CMD_NEXT_SET, bra_pkg::CMD_NEXT_CLR: begin
				pos = scan_for(sz, st, c == bra_pkg::CMD_NEXT_SET);
				a.found = pos < sz;
			end
			bra_pkg::CMD_AREA: begin
				s = st;
				// Each attempt aligns the next clear bit and retries past any set bit.
				for (int tries = 0; tries < MAP_N + 2; tries++) begin
					idx = scan_for(sz, s, 1'b0);
					idx = ((idx + off + msk) & ~msk) - off;
					e = idx + len;
					pos = e;
					if (idx > sz || len > sz - idx) begin
						break;
					end
					hit = scan_for(e, idx, 1'b1);
					if (hit < e) begin
						s = hit + 1;
						continue;
					end
					pos = idx;
					a.found = 1'b1;
					break;
				end
			end
			bra_pkg::CMD_CLR_ALL: shadow_map = '0;
			default: ;
		endcase
		a.position = pos[bra_pkg::POS_W-1:0];
		return a;
	endfunction

	task automatic send_cmd(bra_pkg::cmd_t c, int st, int ln, int am, int ao);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.cmd <= c;
		req.start_pos <= st[bra_pkg::START_W-1:0];
		req.run_length <= ln[bra_pkg::LEN_W-1:0];
		req.area_mask <= am[bra_pkg::ALIGN_W-1:0];
		req.area_offset <= ao[bra_pkg::ALIGN_W-1:0];
		forever begin
			@(posedge clk);
			if (req.ready) begin
				break;
			end
		end
		pending_answers.push_back(predict(c, st[bra_pkg::START_W-1:0],
			ln[bra_pkg::LEN_W-1:0], am[bra_pkg::ALIGN_W-1:0], ao[bra_pkg::ALIGN_W-1:0]));
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_map_size(int value);
		drain();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= bra_pkg::REG_MAP_SIZE;
		pwdata <= bra_pkg::PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready) begin
				break;
			end
		end
		shadow_size = value[bra_pkg::SIZE_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_random(bit noise);
		int k, am, ao, r, ln;
		bra_pkg::cmd_t c;
		if (noise) begin
			send_cmd(bra_pkg::cmd_t'($urandom_range(0, 7)), $urandom_range(0, 1023),
				$urandom_range(0, 2047), $urandom_range(0, 1023), $urandom_range(0, 1023));
			return;
		end
		r = $urandom_range(0, 99);
		ln = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 40);
		if (r < 15) c = bra_pkg::CMD_SET;
		else if (r < 30) c = bra_pkg::CMD_CLR;
		else if (r < 40) c = bra_pkg::CMD_TEST;
		else if (r < 50) c = bra_pkg::CMD_NEXT_SET;
		else if (r < 60) c = bra_pkg::CMD_NEXT_CLR;
		else if (r < 98) c = bra_pkg::CMD_AREA;
		else c = bra_pkg::CMD_CLR_ALL;
		k = $urandom_range(0, 6);
		am = (1 << k) - 1;
		ao = $urandom_range(0, am);
		send_cmd(c, $urandom_range(0, 1023), ln, am, ao);
	endtask

	task automatic test_directed();
		send_cmd(bra_pkg::CMD_NEXT_SET, 0, 0, 0, 0);
		send_cmd(bra_pkg::CMD_NEXT_CLR, 1023, 0, 0, 0);
		send_cmd(bra_pkg::CMD_AREA, 0, 0, 0, 0);
		send_cmd(bra_pkg::CMD_AREA, 0, 1024, 0, 0);
		send_cmd(bra_pkg::CMD_AREA, 1, 1025, 0, 0);
		send_cmd(bra_pkg::CMD_SET, 0, 0, 0, 0);
		send_cmd(bra_pkg::CMD_SET, 1000, 2047, 0, 0);
		send_cmd(bra_pkg::CMD_TEST, 1023, 0, 0, 0);
		send_cmd(bra_pkg::CMD_NEXT_CLR, 1000, 0, 0, 0);
		send_cmd(bra_pkg::CMD_AREA, 990, 0, 0, 0);
		send_cmd(bra_pkg::CMD_SET, 0, 3, 0, 0);
		send_cmd(bra_pkg::CMD_SET, 70, 1, 0, 0);
		send_cmd(bra_pkg::CMD_AREA, 0, 10, 15, 3);
		send_cmd(bra_pkg::CMD_AREA, 0, 8, 1023, 0);
		send_cmd(bra_pkg::CMD_AREA, 5, 4, 5, 7);
		send_cmd(bra_pkg::CMD_AREA, 0, 2, 1023, 1023);
		send_cmd(bra_pkg::CMD_NEXT_SET, 3, 0, 0, 0);
		send_cmd(bra_pkg::CMD_TEST, 70, 0, 0, 0);
		send_cmd(bra_pkg::CMD_CLR, 0, 1024, 0, 0);
		send_cmd(bra_pkg::CMD_TEST, 0, 0, 0, 0);
		send_cmd(bra_pkg::CMD_SET, 5, 10, 0, 0);
		send_cmd(bra_pkg::CMD_CLR_ALL, 0, 0, 0, 0);
		send_cmd(bra_pkg::CMD_NEXT_SET, 0, 0, 0, 0);
		send_cmd(bra_pkg::CMD_NOP, 1023, 2047, 1023, 1023);
	endtask

	task automatic test_map_sizes();
		int sizes[7] = '{1, 0, 2047, 100, 64, 1023, 1024};
		foreach (sizes[n]) begin
			write_map_size(sizes[n]);
			quiet = (n == 3);
			send_cmd(bra_pkg::CMD_SET, 50, 20, 0, 0);
			send_cmd(bra_pkg::CMD_NEXT_SET, 0, 0, 0, 0);
			send_cmd(bra_pkg::CMD_NEXT_CLR, 0, 0, 0, 0);
			send_cmd(bra_pkg::CMD_AREA, 0, 60, 7, 2);
			for (int i = 0; i < 150; i++) begin
				send_random($urandom_range(0, 9) == 0);
			end
		end
		quiet = 0;
	endtask

	task automatic test_backpressure();
		rsp_hold = 2000;
		quiet = 1;
		for (int i = 0; i < 40; i++) begin
			send_random(1'b0);
		end
		quiet = 0;
		// Let every outstanding word arrive before sending more.
		drain();
		for (int i = 0; i < 40; i++) begin
			send_random(1'b0);
		end
	endtask

	// Result side: random stalls after every accepted word outside quiet mode, plus long hold-offs.
	initial begin
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp.ready <= 1'b0;
				rsp_hold--;
			end else if (rsp_wait > 0) begin
				rsp.ready <= 1'b0;
				rsp_wait--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (rsp.valid && rsp.ready) begin
			rsp_wait = quiet ? 0 : $urandom_range(0, 18);
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result word: position %0d found %0b bit %0b",
						rsp.position, rsp.found, rsp.bit_value);
				end
			end else begin
				want = pending_answers.pop_front();
				if (rsp.position !== want.position || rsp.found !== want.found ||
						rsp.bit_value !== want.bit_value) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected pos %0d found %0b bit %0b, got %0d %0b %0b",
							want.position, want.found, want.bit_value,
							rsp.position, rsp.found, rsp.bit_value);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		shadow_map = '0;
		shadow_size = bra_pkg::MAP_SIZE_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_map_sizes();
		test_backpressure();
		drain();
		if (mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
